// ----- rtl/core/pcg32_random_generator_defines.svh -----
// ----------------------------------------------------------------------------
// PCG32 generator assertion macros
// Shared property macros for the checks in the generator's RTL.
// ----------------------------------------------------------------------------
`ifndef PCG32_RANDOM_GENERATOR_DEFINES_SVH
`define PCG32_RANDOM_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCG32_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("pcg32 same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCG32_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("pcg32 next-cycle check failed");

`endif

// ----- rtl/core/pcg32_pkg.sv -----
// ----------------------------------------------------------------------------
// PCG32 generator package
// Types, constants and the XSH RR output function of the generator.
// ----------------------------------------------------------------------------
package pcg32_pkg;

   localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
   localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
   localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];

   localparam logic [62:0] STREAM_RESET    = 63'd1;
   localparam logic [63:0] INCREMENT_RESET = 64'd3;

   localparam logic CMD_DRAW   = 1'b0;
   localparam logic CMD_RESEED = 1'b1;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MUL_LO,
      SEQ_MUL_X1,
      SEQ_MUL_X2,
      SEQ_FINISH
   } seq_state_type;

   // XSH RR output of one LCG state.
   function automatic logic [31:0] xsh_rr(input logic [63:0] old);
      logic [63:0] mixed;
      logic [31:0] xs;
      logic [4:0]  rot;
      logic [63:0] doubled;
      mixed   = (old >> 18) ^ old;
      xs      = mixed[58:27];
      rot     = old[63:59];
      doubled = {xs, xs} >> rot;
      return doubled[31:0];
   endfunction

endpackage

// ----- rtl/core/pcg32_channels.sv -----
// ----------------------------------------------------------------------------
// PCG32 generator channels
// Valid/ready interfaces for the command and the random word channels.
// ----------------------------------------------------------------------------
interface pcg32_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [63:0] seed_value;

   modport source (output valid, output command, output seed_value, input ready);
   modport sink   (input valid, input command, input seed_value, output ready);
endinterface

interface pcg32_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

// ----- rtl/core/pcg32_random_generator.sv -----
// A command word is accepted only in the idle state, so the next one waits until
// the previous one finishes; the 64-bit state update runs as three passes of one
// shared 32x32 multiplier and a final add.
// A finished draw may wait in the output register while the next word is taken.
// Reset (synchronous): state 0, increment 3, stream select 1, no word pending.
// ----------------------------------------------------------------------------
// PCG32 random generator
// PCG32 with XSH RR output; draw and reseed commands on a valid/ready channel.
// ----------------------------------------------------------------------------
`include "pcg32_random_generator_defines.svh"

module pcg32_random_generator (
   input  logic               clock,
   input  logic               reset,
   pcg32_req_if.sink          req_if,
   pcg32_rsp_if.source        rsp_if,
   input  logic               csr_write_enable,
   input  logic [62:0]        csr_write_data
);

   pcg32_pkg::seq_state_type seq_ff, seq_in;

   logic [62:0] stream_ff;
   logic [63:0] state_ff, state_in;
   logic [63:0] inc_ff, inc_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff;
   logic        draw_ff, draw_in;
   logic [31:0] word_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff;
   logic        load_rsp;
   logic [31:0] mul_a, mul_b;
   logic        accept;
   logic [63:0] new_inc;
   logic [63:0] upper_add;

   assign accept    = req_if.valid && req_if.ready;
   assign new_inc   = {stream_ff, 1'b1};
   assign upper_add = {prod_ff[31:0], 32'h0};

   always_comb begin
      seq_in       = seq_ff;
      state_in     = state_ff;
      inc_in       = inc_ff;
      acc_in       = acc_ff;
      draw_in      = draw_ff;
      load_rsp     = 1'b0;
      req_if.ready = 1'b0;
      mul_a        = state_ff[31:0];
      mul_b        = pcg32_pkg::LCG_MULT_LO;
      case (seq_ff)
         pcg32_pkg::SEQ_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               draw_in = (req_if.command == pcg32_pkg::CMD_DRAW);
               if (req_if.command == pcg32_pkg::CMD_RESEED) begin
                  // Advancing from zero leaves the increment, then the seed is added.
                  inc_in   = new_inc;
                  state_in = new_inc + req_if.seed_value;
               end
               seq_in = pcg32_pkg::SEQ_MUL_LO;
            end
         end
         pcg32_pkg::SEQ_MUL_LO: begin
            seq_in = pcg32_pkg::SEQ_MUL_X1;
         end
         pcg32_pkg::SEQ_MUL_X1: begin
            mul_b  = pcg32_pkg::LCG_MULT_HI;
            acc_in = prod_ff + (inc_ff | 64'd1);
            seq_in = pcg32_pkg::SEQ_MUL_X2;
         end
         pcg32_pkg::SEQ_MUL_X2: begin
            mul_a  = state_ff[63:32];
            acc_in = acc_ff + upper_add;
            seq_in = pcg32_pkg::SEQ_FINISH;
         end
         pcg32_pkg::SEQ_FINISH: begin
            // The last partial product must stay steady while a draw waits.
            mul_a = state_ff[63:32];
            // A draw holds here until the output register is free.
            if (!draw_ff || !rsp_valid_ff || rsp_if.ready) begin
               state_in = acc_ff + upper_add;
               load_rsp = draw_ff;
               seq_in   = pcg32_pkg::SEQ_IDLE;
            end
         end
         default: begin
            seq_in = pcg32_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= pcg32_pkg::SEQ_IDLE;
         stream_ff    <= pcg32_pkg::STREAM_RESET;
         state_ff     <= 64'h0;
         inc_ff       <= pcg32_pkg::INCREMENT_RESET;
         rsp_valid_ff <= 1'b0;
         draw_ff      <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         state_ff     <= state_in;
         inc_ff       <= inc_in;
         rsp_valid_ff <= rsp_valid_in;
         draw_ff      <= draw_in;
         if (csr_write_enable) begin
            stream_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
      if (accept) begin
         word_ff <= pcg32_pkg::xsh_rr(state_ff);
      end
      if (load_rsp) begin
         rsp_word_ff <= word_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.random_word = rsp_word_ff;

   `PCG32_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(load_rsp))
   `PCG32_ASSERT_SAME(a_increment_odd, clock, reset, 1'b1, inc_ff[0] == 1'b1)
   `PCG32_ASSERT_NEXT(a_accept_starts, clock, reset, accept, seq_ff == pcg32_pkg::SEQ_MUL_LO)

endmodule

// ----- sim/tb_pcg32_random_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCG32 random generator testbench
// Feeds draw and reseed command words through a bursty driver and checks each
// random word against a local XSH RR predictor. The stream select register is
// reprogrammed between phases, including both of its extreme values.
// ----------------------------------------------------------------------------
module tb_pcg32_random_generator;

   localparam int CLOCK_HALF     = 2;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_WORDS    = 200;
   localparam int REPORT_LIMIT   = 10;
   // Watchdog limit on the whole run.
   localparam int CYCLE_LIMIT    = 400000;
   localparam logic [62:0] STREAM_MAX = {63{1'b1}};

   typedef struct packed {
      logic        command;
      logic [63:0] seed_value;
   } command_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [62:0] csr_write_data;

   pcg32_req_if req_bus ();
   pcg32_rsp_if rsp_bus ();

   pcg32_random_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Local copy of the generator and its stream register.
   logic [62:0] stream_setting = pcg32_pkg::STREAM_RESET;
   logic [63:0] gen_state      = 64'd0;
   logic [63:0] gen_increment  = pcg32_pkg::INCREMENT_RESET;

   command_word_type pending_words[$];
   logic [31:0]      expected_words[$];
   command_word_type word_on_bus;
   int               error_count = 0;
   int               cycle_count = 0;
   int               burst_left  = 1;
   int               gap_left    = 0;
   logic [15:0]      stall_mask  = 16'hFFFF;
   int               mask_age    = 0;

   function automatic logic [31:0] word_of_state(input logic [63:0] s);
      logic [31:0] folded;
      logic [4:0]  amount;
      folded = 32'((s ^ (s >> 18)) >> 27);
      amount = s[63:59];
      // A left shift by 32 yields zero, so a zero rotation passes the word through.
      return (folded >> amount) | (folded << (6'd32 - {1'b0, amount}));
   endfunction

   function automatic logic [31:0] step_generator();
      logic [31:0] word;
      word = word_of_state(gen_state);
      gen_state = gen_state * pcg32_pkg::LCG_MULT + (gen_increment | 64'd1);
      return word;
   endfunction

   function automatic void predict_command(input command_word_type cw);
      if (cw.command == pcg32_pkg::CMD_RESEED) begin
         gen_state = 64'd0;
         gen_increment = {stream_setting, 1'b1};
         void'(step_generator());
         gen_state = gen_state + cw.seed_value;
         void'(step_generator());
      end else begin
         expected_words.push_back(step_generator());
      end
   endfunction

   function automatic void queue_word(input logic command, input logic [63:0] seed);
      command_word_type cw;
      cw.command = command;
      cw.seed_value = seed;
      pending_words.push_back(cw);
   endfunction

   function automatic logic [63:0] random_seed();
      return {$urandom(), $urandom()};
   endfunction

   // Wait until every queued word is accepted and answered, then let the
   // generator finish any reseed still in progress.
   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stream(input logic [62:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      stream_setting = value;
   endtask

   // Command word driver with bursts and random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.command    <= pcg32_pkg::CMD_DRAW;
         req_bus.seed_value <= 64'd0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_command(word_on_bus);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || pending_words.size() == 0) begin
               if (gap_left > 0) begin
                  gap_left--;
               end
               req_bus.valid <= 1'b0;
            end else begin
               word_on_bus = pending_words.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.command    <= word_on_bus.command;
               req_bus.seed_value <= word_on_bus.seed_value;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               end
            end
         end
      end
   end

   // Random word monitor; ready follows a rotating stall mask.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("unexpected random word %h", rsp_bus.random_word);
               end
               error_count++;
            end else if (rsp_bus.random_word !== expected_words[0]) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("random_word mismatch: expected %h, actual %h",
                           expected_words[0], rsp_bus.random_word);
               end
               error_count++;
               void'(expected_words.pop_front());
            end else begin
               void'(expected_words.pop_front());
            end
         end
         mask_age++;
         if (mask_age >= 200) begin
            mask_age = 0;
            stall_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
         end
         stall_mask = {stall_mask[0], stall_mask[15:1]};
         rsp_bus.ready <= stall_mask[0];
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: draws from the reset state (zero rotation first), then
      // reseeds with extreme seeds under the reset stream.
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, {64{1'b1}});
      queue_word(pcg32_pkg::CMD_RESEED, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_RESEED, {64{1'b1}});
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_RESEED, 64'h8000_0000_0000_0000);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);

      wait_until_idle();
      write_stream(STREAM_MAX);
      queue_word(pcg32_pkg::CMD_RESEED, random_seed());
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);

      wait_until_idle();
      write_stream(63'd0);
      queue_word(pcg32_pkg::CMD_RESEED, 64'd1);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_DRAW, 64'd0);
      queue_word(pcg32_pkg::CMD_RESEED, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_word(pcg32_pkg::CMD_DRAW, {64{1'b1}});

      // Random phases, each opening with a stream write and a reseed.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         logic [62:0] stream;
         wait_until_idle();
         case (phase % 4)
            0: begin
               stream = 63'd0;
            end
            1: begin
               stream = STREAM_MAX;
            end
            2: begin
               stream = pcg32_pkg::STREAM_RESET;
            end
            default: begin
               stream = 63'({$urandom(), $urandom()});
            end
         endcase
         write_stream(stream);
         queue_word(pcg32_pkg::CMD_RESEED, random_seed());
         for (int n = 1; n < PHASE_WORDS; n++) begin
            queue_word(($urandom_range(0, 7) == 0) ? pcg32_pkg::CMD_RESEED : pcg32_pkg::CMD_DRAW,
                       random_seed());
         end
      end

      wait_until_idle();
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
